### rtl/triangle_plane_clipper_defines.svh
// Assertion macros used by the clipper sequencer.
// They expect clk and arst_n in the scope of the use.
`ifndef TRIANGLE_PLANE_CLIPPER_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_DEFINES_SVH

`define TPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tpc_pkg.sv
`timescale 1ns / 1ps
package tpc_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int TFRAC_BITS  = 40;
	localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 3;
	localparam int PROD_WIDTH  = COORD_WIDTH + TFRAC_BITS + 2;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLANE_PX  = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLANE_PY  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLANE_PZ  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_NX = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_NY = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_NZ = 3'd5;

	localparam logic [1:0] NI_NONE = 2'd0;
	localparam logic [1:0] NI_ONE  = 2'd1;
	localparam logic [1:0] NI_TWO  = 2'd2;
	localparam logic [1:0] NI_ALL  = 2'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COORD_WIDTH:0]   diff_t;
	typedef logic signed [DIST_WIDTH-1:0]  dist_t;
	typedef logic [DIST_WIDTH-1:0]         udist_t;
	typedef logic [TFRAC_BITS-1:0]         frac_t;
	typedef logic [1:0]                    vidx_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vert_t;

	typedef struct packed {
		coord_t v0_x;
		coord_t v0_y;
		coord_t v0_z;
		coord_t v0_w;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v1_z;
		coord_t v1_w;
		coord_t v2_x;
		coord_t v2_y;
		coord_t v2_z;
		coord_t v2_w;
	} tri_in_t;

	typedef struct packed {
		coord_t     out_x;
		coord_t     out_y;
		coord_t     out_z;
		coord_t     out_w;
		logic [1:0] triangle_count;
		logic [2:0] vertex_slot;
		logic       last;
	} vtx_out_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		coord_t pz;
		coord_t nx;
		coord_t ny;
		coord_t nz;
	} plane_t;

	typedef struct packed {
		vert_t       a;
		diff_t [3:0] dl;
	} cut_t;

	typedef struct packed {
		vert_t [2:0] v;
		logic [1:0]  ni;
		vidx_t       i0;
		vidx_t       i1;
		cut_t [1:0]  cut;
	} clip_ctx_t;

	typedef struct packed {
		vert_t [2:0] v;
		logic [1:0]  ni;
		vidx_t       i0;
		vidx_t       i1;
		vert_t [1:0] x;
	} clip_res_t;

	function automatic vert_t pick_vert(vert_t [2:0] v, vidx_t i);
		vert_t r;
		case (i)
			2'd1:    r = v[1];
			2'd2:    r = v[2];
			default: r = v[0];
		endcase
		return r;
	endfunction

	function automatic coord_t get_coord(vert_t v, logic [1:0] k);
		coord_t r;
		case (k)
			2'd0:    r = v.x;
			2'd1:    r = v.y;
			2'd2:    r = v.z;
			default: r = v.w;
		endcase
		return r;
	endfunction

endpackage

### rtl/tpc_dist.sv
`timescale 1ns / 1ps
module tpc_dist import tpc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tri_in_t         in_word,
	input  plane_t          plane,
	output logic            vld_s3,
	output clip_ctx_t       ctx_s3,
	output udist_t [1:0]    rem_s3,
	output udist_t [1:0]    den_s3
);

	vert_t [2:0] vin;
	vert_t [2:0] v_s1;
	vert_t [2:0] v_s2;
	logic signed [2*COORD_WIDTH-1:0] nv_s1 [3][3];
	logic signed [2*COORD_WIDTH-1:0] pp_s1 [3];
	dist_t [2:0] d_s2;
	logic        vld_s1;
	logic        vld_s2;

	logic [2:0]  ib;
	logic [1:0]  ni;
	vidx_t       i0, i1, o0, o1;
	vidx_t       ba, bb;
	dist_t       da_a, db_a, da_b, db_b;
	vert_t       va_a, vb_a, va_b, vb_b;
	clip_ctx_t   ctx_d;

	function automatic dist_t pick_dist(dist_t [2:0] d, vidx_t i);
		dist_t r;
		case (i)
			2'd1:    r = d[1];
			2'd2:    r = d[2];
			default: r = d[0];
		endcase
		return r;
	endfunction

	assign vin[0] = {in_word.v0_x, in_word.v0_y, in_word.v0_z, in_word.v0_w};
	assign vin[1] = {in_word.v1_x, in_word.v1_y, in_word.v1_z, in_word.v1_w};
	assign vin[2] = {in_word.v2_x, in_word.v2_y, in_word.v2_z, in_word.v2_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nv_s1[i][0] <= plane.nx * vin[i].x;
				nv_s1[i][1] <= plane.ny * vin[i].y;
				nv_s1[i][2] <= plane.nz * vin[i].z;
				d_s2[i] <= dist_t'(nv_s1[i][0]) + dist_t'(nv_s1[i][1])
					+ dist_t'(nv_s1[i][2]) - dist_t'(pp_s1[0])
					- dist_t'(pp_s1[1]) - dist_t'(pp_s1[2]);
			end
			pp_s1[0] <= plane.nx * plane.px;
			pp_s1[1] <= plane.ny * plane.py;
			pp_s1[2] <= plane.nz * plane.pz;
			v_s1     <= vin;
			v_s2     <= v_s1;
			ctx_s3   <= ctx_d;
			rem_s3[0] <= udist_t'(da_a);
			rem_s3[1] <= udist_t'(da_b);
			den_s3[0] <= udist_t'(da_a - db_a);
			den_s3[1] <= udist_t'(da_b - db_b);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ib[i] = ~d_s2[i][DIST_WIDTH-1];
		end
		ni = NI_NONE;
		i0 = 2'd0;
		i1 = 2'd0;
		o0 = 2'd0;
		o1 = 2'd0;
		unique case (ib)
			3'b001: begin ni = NI_ONE; i0 = 2'd0; o0 = 2'd1; o1 = 2'd2; end
			3'b010: begin ni = NI_ONE; i0 = 2'd1; o0 = 2'd0; o1 = 2'd2; end
			3'b100: begin ni = NI_ONE; i0 = 2'd2; o0 = 2'd0; o1 = 2'd1; end
			3'b011: begin ni = NI_TWO; i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; end
			3'b101: begin ni = NI_TWO; i0 = 2'd0; i1 = 2'd2; o0 = 2'd1; end
			3'b110: begin ni = NI_TWO; i0 = 2'd1; i1 = 2'd2; o0 = 2'd0; end
			3'b111: ni = NI_ALL;
			default: ni = NI_NONE;
		endcase
		ba = (ni == NI_ONE) ? i0 : i1;
		bb = (ni == NI_ONE) ? o1 : o0;
		da_a = pick_dist(d_s2, i0);
		db_a = pick_dist(d_s2, o0);
		da_b = pick_dist(d_s2, ba);
		db_b = pick_dist(d_s2, bb);
		va_a = pick_vert(v_s2, i0);
		vb_a = pick_vert(v_s2, o0);
		va_b = pick_vert(v_s2, ba);
		vb_b = pick_vert(v_s2, bb);
		ctx_d.v  = v_s2;
		ctx_d.ni = ni;
		ctx_d.i0 = i0;
		ctx_d.i1 = i1;
		ctx_d.cut[0].a     = va_a;
		ctx_d.cut[0].dl[0] = diff_t'(vb_a.x) - diff_t'(va_a.x);
		ctx_d.cut[0].dl[1] = diff_t'(vb_a.y) - diff_t'(va_a.y);
		ctx_d.cut[0].dl[2] = diff_t'(vb_a.z) - diff_t'(va_a.z);
		ctx_d.cut[0].dl[3] = diff_t'(vb_a.w) - diff_t'(va_a.w);
		ctx_d.cut[1].a     = va_b;
		ctx_d.cut[1].dl[0] = diff_t'(vb_b.x) - diff_t'(va_b.x);
		ctx_d.cut[1].dl[1] = diff_t'(vb_b.y) - diff_t'(va_b.y);
		ctx_d.cut[1].dl[2] = diff_t'(vb_b.z) - diff_t'(va_b.z);
		ctx_d.cut[1].dl[3] = diff_t'(vb_b.w) - diff_t'(va_b.w);
	end

endmodule

### rtl/tpc_div.sv
`timescale 1ns / 1ps
module tpc_div import tpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  clip_ctx_t    ctx_in,
	input  udist_t [1:0] rem_in,
	input  udist_t [1:0] den_in,
	output logic         vld_out,
	output clip_ctx_t    ctx_out,
	output frac_t [1:0]  q_out
);

	// One quotient bit per stage, both cuts side by side.
	logic      vld_sd [TFRAC_BITS];
	clip_ctx_t ctx_sd [TFRAC_BITS];
	udist_t    rem_sd [TFRAC_BITS][2];
	udist_t    den_sd [TFRAC_BITS][2];
	frac_t     q_sd   [TFRAC_BITS][2];

	for (genvar k = 0; k < TFRAC_BITS; k++) begin : g_step
		logic      p_vld;
		clip_ctx_t p_ctx;
		udist_t    p_rem [2];
		udist_t    p_den [2];
		frac_t     p_q   [2];
		logic [DIST_WIDTH:0] rem2 [2];
		logic [DIST_WIDTH:0] diff [2];
		logic      ge   [2];

		if (k == 0) begin : g_first
			assign p_vld    = vld_in;
			assign p_ctx    = ctx_in;
			assign p_rem[0] = rem_in[0];
			assign p_rem[1] = rem_in[1];
			assign p_den[0] = den_in[0];
			assign p_den[1] = den_in[1];
			assign p_q[0]   = '0;
			assign p_q[1]   = '0;
		end else begin : g_next
			assign p_vld    = vld_sd[k-1];
			assign p_ctx    = ctx_sd[k-1];
			assign p_rem[0] = rem_sd[k-1][0];
			assign p_rem[1] = rem_sd[k-1][1];
			assign p_den[0] = den_sd[k-1][0];
			assign p_den[1] = den_sd[k-1][1];
			assign p_q[0]   = q_sd[k-1][0];
			assign p_q[1]   = q_sd[k-1][1];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				rem2[l] = {p_rem[l], 1'b0};
				diff[l] = rem2[l] - {1'b0, p_den[l]};
				ge[l]   = rem2[l] >= {1'b0, p_den[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (en) begin
				vld_sd[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_sd[k] <= p_ctx;
				for (int l = 0; l < 2; l++) begin
					rem_sd[k][l] <= ge[l] ? diff[l][DIST_WIDTH-1:0] : rem2[l][DIST_WIDTH-1:0];
					den_sd[k][l] <= p_den[l];
					q_sd[k][l]   <= {p_q[l][TFRAC_BITS-2:0], ge[l]};
				end
			end
		end
	end

	assign vld_out  = vld_sd[TFRAC_BITS-1];
	assign ctx_out  = ctx_sd[TFRAC_BITS-1];
	assign q_out[0] = q_sd[TFRAC_BITS-1][0];
	assign q_out[1] = q_sd[TFRAC_BITS-1][1];

endmodule

### rtl/tpc_lerp.sv
`timescale 1ns / 1ps
module tpc_lerp import tpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  clip_ctx_t   ctx_in,
	input  frac_t [1:0] tf,
	output logic        res_vld,
	output clip_res_t   res
);

	localparam int TF_LO    = TFRAC_BITS / 2;
	localparam int TF_HI    = TFRAC_BITS - TF_LO;
	localparam int PP_WIDTH = COORD_WIDTH + TF_HI + 2;

	localparam logic signed [PROD_WIDTH-1:0] HALF =
		{{(PROD_WIDTH-TFRAC_BITS){1'b0}}, 1'b1, {(TFRAC_BITS-1){1'b0}}};
	localparam logic signed [COORD_WIDTH+1:0] CMAX = {3'b000, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH+1:0] CMIN = {3'b111, {(COORD_WIDTH-1){1'b0}}};

	// The fraction is split in two halves so that each multiplier stays narrow.
	logic signed [PP_WIDTH-1:0]   plo_s1  [2][4];
	logic signed [PP_WIDTH-1:0]   phi_s1  [2][4];
	logic signed [PROD_WIDTH-1:0] rsum_s2 [2][4];
	clip_ctx_t ctx_s1;
	clip_ctx_t ctx_s2;
	logic      vld_s1;
	logic      vld_s2;

	logic signed [COORD_WIDTH+1:0] off  [2][4];
	logic signed [COORD_WIDTH+1:0] tot  [2][4];
	coord_t                        ac   [2][4];
	coord_t                        xc   [2][4];
	clip_res_t                     res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			res_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			res_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 2; c++) begin
				for (int k = 0; k < 4; k++) begin
					plo_s1[c][k] <= PP_WIDTH'(ctx_in.cut[c].dl[k])
						* PP_WIDTH'($signed({1'b0, tf[c][TF_LO-1:0]}));
					phi_s1[c][k] <= PP_WIDTH'(ctx_in.cut[c].dl[k])
						* PP_WIDTH'($signed({1'b0, tf[c][TFRAC_BITS-1:TF_LO]}));
					rsum_s2[c][k] <= (PROD_WIDTH'(phi_s1[c][k]) <<< TF_LO)
						+ PROD_WIDTH'(plo_s1[c][k]) + HALF;
				end
			end
			ctx_s1 <= ctx_in;
			ctx_s2 <= ctx_s1;
			res    <= res_d;
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			for (int k = 0; k < 4; k++) begin
				off[c][k]  = rsum_s2[c][k][PROD_WIDTH-1:TFRAC_BITS];
				ac[c][k]   = get_coord(ctx_s2.cut[c].a, 2'(k));
				tot[c][k]  = (COORD_WIDTH+2)'(ac[c][k]) + off[c][k];
				if (tot[c][k] > CMAX) begin
					xc[c][k] = CMAX[COORD_WIDTH-1:0];
				end else if (tot[c][k] < CMIN) begin
					xc[c][k] = CMIN[COORD_WIDTH-1:0];
				end else begin
					xc[c][k] = tot[c][k][COORD_WIDTH-1:0];
				end
			end
		end
		res_d.v    = ctx_s2.v;
		res_d.ni   = ctx_s2.ni;
		res_d.i0   = ctx_s2.i0;
		res_d.i1   = ctx_s2.i1;
		res_d.x[0] = {xc[0][0], xc[0][1], xc[0][2], xc[0][3]};
		res_d.x[1] = {xc[1][0], xc[1][1], xc[1][2], xc[1][3]};
	end

endmodule

### rtl/tpc_seq.sv
`timescale 1ns / 1ps
`include "triangle_plane_clipper_defines.svh"
module tpc_seq import tpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_vld,
	input  clip_res_t res,
	output logic      ready,
	output logic      out_valid,
	input  logic      out_stall,
	output vtx_out_t  out_word
);

	logic       busy_q;
	logic [2:0] slot_q;
	logic [2:0] last_slot_q;
	logic [1:0] tcount_q;
	logic       out_vld_q;
	vtx_out_t   out_q;
	vert_t      slots_q [6];

	logic       out_adv, emit, done, take, load;
	vert_t      slots_d [6];
	logic [2:0] last_slot_d;
	logic [1:0] tcount_d;
	vert_t      va, vb;

	assign out_adv = !out_vld_q || !out_stall;
	assign emit    = busy_q && out_adv;
	assign done    = emit && (slot_q == last_slot_q);
	assign ready   = !busy_q || done;
	assign take    = res_vld && ready;
	assign load    = take && (res.ni != NI_NONE);

	always_comb begin
		va = pick_vert(res.v, res.i0);
		vb = pick_vert(res.v, res.i1);
		for (int s = 0; s < 6; s++) begin
			slots_d[s] = va;
		end
		last_slot_d = 3'd2;
		tcount_d    = 2'd1;
		case (res.ni)
			NI_ALL: begin
				slots_d[0] = res.v[0];
				slots_d[1] = res.v[1];
				slots_d[2] = res.v[2];
			end
			NI_TWO: begin
				slots_d[1] = vb;
				slots_d[2] = res.x[0];
				slots_d[3] = vb;
				slots_d[4] = res.x[0];
				slots_d[5] = res.x[1];
				last_slot_d = 3'd5;
				tcount_d    = 2'd2;
			end
			default: begin
				slots_d[1] = res.x[0];
				slots_d[2] = res.x[1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= '0;
			last_slot_q <= '0;
			tcount_q    <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= 1'b1;
				slot_q      <= '0;
				last_slot_q <= last_slot_d;
				tcount_q    <= tcount_d;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (emit) begin
					slot_q <= slot_q + 3'd1;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_adv) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= slots_d;
		end
		if (emit) begin
			out_q.out_x          <= slots_q[slot_q].x;
			out_q.out_y          <= slots_q[slot_q].y;
			out_q.out_z          <= slots_q[slot_q].z;
			out_q.out_w          <= slots_q[slot_q].w;
			out_q.triangle_count <= tcount_q;
			out_q.vertex_slot    <= slot_q;
			out_q.last           <= (slot_q == last_slot_q);
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	`TPC_ASSERT_NOW(a_slot_range, busy_q, slot_q <= last_slot_q, "Vertex slot ran past the end of the word.")
	`TPC_ASSERT_NOW(a_more_after, out_vld_q && !out_q.last, busy_q, "Sequencer went idle before the last vertex.")
	`TPC_ASSERT_NEXT(a_two_tri, load && (res.ni == NI_TWO), (last_slot_q == 3'd5) && (tcount_q == 2'd2), "Two-triangle word loaded with the wrong length.")
	`TPC_ASSERT_NEXT(a_hold_end, busy_q && !done, $stable(last_slot_q), "Word length changed while vertices were pending.")

endmodule

### rtl/triangle_plane_clipper.sv
`timescale 1ns / 1ps
// Pipeline: three distance stages, one divider stage per quotient bit, three interpolation
// stages, then the sequencer. A new triangle may enter every cycle while in_stall is low;
// the output register gives one vertex a cycle while out_stall is low, 3 vertices per
// triangle, 6 when it splits in two, none when fully clipped.
// Reset: arst_n clears all valid bits, the sequencer and the plane to point 0, normal +z.
module triangle_plane_clipper import tpc_pkg::*; #(
	parameter int FRAC_BITS_P = FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tri_in_t                    in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output vtx_out_t                   out_word,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  coord_t                     cfg_data
);

	localparam coord_t NZ_RESET = COORD_WIDTH'(64'd1 << FRAC_BITS_P);

	plane_t       plane_q;
	logic         en;
	logic         d_vld;
	clip_ctx_t    d_ctx;
	udist_t [1:0] d_rem;
	udist_t [1:0] d_den;
	logic         q_vld;
	clip_ctx_t    q_ctx;
	frac_t [1:0]  q_tf;
	logic         res_vld;
	clip_res_t    res;
	logic         seq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.px <= '0;
			plane_q.py <= '0;
			plane_q.pz <= '0;
			plane_q.nx <= '0;
			plane_q.ny <= '0;
			plane_q.nz <= NZ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLANE_PX:  plane_q.px <= cfg_data;
				CFG_PLANE_PY:  plane_q.py <= cfg_data;
				CFG_PLANE_PZ:  plane_q.pz <= cfg_data;
				CFG_NORMAL_NX: plane_q.nx <= cfg_data;
				CFG_NORMAL_NY: plane_q.ny <= cfg_data;
				CFG_NORMAL_NZ: plane_q.nz <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !res_vld || seq_ready;
	assign in_stall = !en;

	tpc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_word  (in_word),
		.plane    (plane_q),
		.vld_s3   (d_vld),
		.ctx_s3   (d_ctx),
		.rem_s3   (d_rem),
		.den_s3   (d_den)
	);

	tpc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (d_vld),
		.ctx_in  (d_ctx),
		.rem_in  (d_rem),
		.den_in  (d_den),
		.vld_out (q_vld),
		.ctx_out (q_ctx),
		.q_out   (q_tf)
	);

	tpc_lerp u_lerp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (q_vld),
		.ctx_in  (q_ctx),
		.tf      (q_tf),
		.res_vld (res_vld),
		.res     (res)
	);

	tpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_vld   (res_vld),
		.res       (res),
		.ready     (seq_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
